>>> design/sqvs_pkg.sv
// shared types, constants and tables of the sprite quad vertex setup unit
`timescale 1ns / 1ps
`default_nettype none
package sqvs_pkg;

  // default parameter values
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // configuration register indexes
  localparam logic [7:0] CFG_TEX_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_TEX_HEIGHT = 8'd1;

  // angle constants, signed with 30 fraction bits
  localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [34:0] ANG_TWO_PI  = 35'sd6746518852;
  localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i, 30 fraction bits
  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // one sprite description
  typedef struct packed {
    logic [63:0]        dest_pos;
    logic [63:0]        dest_size;
    logic [63:0]        src_pos;
    logic [63:0]        src_size;
    logic [63:0]        origin_pt;
    logic signed [15:0] rotation;
    logic signed [31:0] depth;
    logic [31:0]        color;
    logic [1:0]         flip_effects;
    logic [1:0]         orientation;
    logic [7:0]         swizzle;
  } in_item_t;

  // one quad vertex
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        color_out;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [7:0]         swizzle_out;
    logic               last_vertex;
  } out_item_t;

  // per-sprite values carried beside the vertex math
  typedef struct packed {
    logic signed [31:0] tu0;
    logic signed [31:0] tu1;
    logic signed [31:0] tv0;
    logic signed [31:0] tv1;
    logic signed [31:0] depth;
    logic [31:0]        color;
    logic [1:0]         flip;
    logic [1:0]         orient;
    logic [7:0]         swizzle;
  } side_t;

endpackage
`default_nettype wire

>>> design/sqvs_div.sv
// pipelined restoring divider, one quotient bit per stage, signed 32-bit saturated result
`timescale 1ns / 1ps
`default_nettype none
module sqvs_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [NUM_W:0] num_i,
  input  wire logic [DEN_W-1:0]      den_i,
  output logic signed [31:0]         quo_o
);

  logic [NUM_W-1:0] n_q   [NUM_W+1];
  logic [DEN_W-1:0] r_q   [NUM_W+1];
  logic [DEN_W-1:0] d_q   [NUM_W+1];
  logic             neg_q [NUM_W+1];
  logic signed [31:0] quo_q;

  // magnitude and sign of the numerator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= num_i[NUM_W] ? NUM_W'(-num_i) : num_i[NUM_W-1:0];
      r_q[0]   <= '0;
      d_q[0]   <= den_i;
      neg_q[0] <= num_i[NUM_W];
    end
  end

  // one quotient bit per stage, quotient shifts in where numerator bits leave
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    assign trial = {r_q[s], n_q[s][NUM_W-1]};
    assign diff  = trial - {1'b0, d_q[s]};
    assign ge    = trial >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_q[s+1]   <= {n_q[s][NUM_W-2:0], ge};
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // sign and saturation
  logic [NUM_W-1:0] q;
  logic             ovf_pos;
  logic             ovf_neg;
  assign q       = n_q[NUM_W];
  assign ovf_pos = |q[NUM_W-1:31];
  assign ovf_neg = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[NUM_W]) begin
        quo_q <= ovf_neg ? 32'sh80000000 : -$signed(q[31:0]);
      end else begin
        quo_q <= ovf_pos ? 32'sh7FFFFFFF : $signed(q[31:0]);
      end
    end
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire

>>> design/sqvs_cordic.sv
// pipelined rotation-mode cordic giving cos and sin with 30 fraction bits
`timescale 1ns / 1ps
`default_nettype none
module sqvs_cordic #(
  parameter int unsigned STEPS = sqvs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] rot_i,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  logic signed [34:0] a0_q;
  logic signed [34:0] a1_q;
  logic               zero0_q;
  logic               zero1_q;
  logic signed [33:0] x_q [STEPS+1];
  logic signed [33:0] y_q [STEPS+1];
  logic signed [33:0] z_q [STEPS+1];
  logic               zf_q [STEPS+1];
  logic               nf_q [STEPS+1];
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;

  // scale Q4.12 to 30 fraction bits, then reduce once by two pi
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q    <= $signed({rot_i[15], rot_i, 18'd0});
      zero0_q <= (rot_i == 16'sd0);
      if (a0_q > sqvs_pkg::ANG_PI) begin
        a1_q <= a0_q - sqvs_pkg::ANG_TWO_PI;
      end else if (a0_q < -sqvs_pkg::ANG_PI) begin
        a1_q <= a0_q + sqvs_pkg::ANG_TWO_PI;
      end else begin
        a1_q <= a0_q;
      end
      zero1_q <= zero0_q;
    end
  end

  // fold into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= sqvs_pkg::CORDIC_GAIN;
      y_q[0]  <= '0;
      zf_q[0] <= zero1_q;
      if (a1_q > sqvs_pkg::ANG_HALF_PI) begin
        z_q[0]  <= 34'(a1_q - sqvs_pkg::ANG_PI);
        nf_q[0] <= 1'b1;
      end else if (a1_q < -sqvs_pkg::ANG_HALF_PI) begin
        z_q[0]  <= 34'(a1_q + sqvs_pkg::ANG_PI);
        nf_q[0] <= 1'b1;
      end else begin
        z_q[0]  <= 34'(a1_q);
        nf_q[0] <= 1'b0;
      end
    end
  end

  // micro-rotations
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [33:0] atan_s;
    assign atan_s = $signed({2'b00, sqvs_pkg::ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 34'sd0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_s;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_s;
        end
        zf_q[i+1] <= zf_q[i];
        nf_q[i+1] <= nf_q[i];
      end
    end
  end

  // undo the fold, zero angle gives the identity
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zf_q[STEPS]) begin
        cos_q <= 32'sh40000000;
        sin_q <= '0;
      end else if (nf_q[STEPS]) begin
        cos_q <= 32'(-x_q[STEPS]);
        sin_q <= 32'(-y_q[STEPS]);
      end else begin
        cos_q <= 32'(x_q[STEPS]);
        sin_q <= 32'(y_q[STEPS]);
      end
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
`default_nettype wire

>>> design/sqvs_vtx.sv
// five-stage vertex math: corner offsets, scale, rotate and translate for all four corners
`timescale 1ns / 1ps
`default_nettype none
module sqvs_vtx #(
  parameter int unsigned FRAC_BITS = sqvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [31:0]  rx_i,
  input  wire logic signed [31:0]  ry_i,
  input  wire logic signed [31:0]  cs_i,
  input  wire logic signed [31:0]  sn_i,
  input  wire logic signed [31:0]  dx_i,
  input  wire logic signed [31:0]  dy_i,
  input  wire logic signed [31:0]  dw_i,
  input  wire logic signed [31:0]  dh_i,
  input  wire sqvs_pkg::side_t     side_i,
  output logic [3:0][31:0]         vx_o,
  output logic [3:0][31:0]         vy_o,
  output sqvs_pkg::side_t          side_o
);

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dw;
    logic signed [31:0] dh;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  ctx_t            c1_q, c2_q, c3_q, c4_q;
  sqvs_pkg::side_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [31:0] ex_q  [2];
  logic signed [31:0] ey_q  [2];
  logic signed [63:0] mx_q  [2];
  logic signed [63:0] my_q  [2];
  logic signed [31:0] px_q  [2];
  logic signed [31:0] py_q  [2];
  logic signed [63:0] pxc_q [2];
  logic signed [63:0] pxs_q [2];
  logic signed [63:0] pyc_q [2];
  logic signed [63:0] pys_q [2];
  logic [3:0][31:0]   vx_q;
  logic [3:0][31:0]   vy_q;

  // corner minus origin ratio, left or right and top or bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q[0] <= sat32(66'(-(34'(rx_i))));
      ex_q[1] <= sat32(66'(ONE - 34'(rx_i)));
      ey_q[0] <= sat32(66'(-(34'(ry_i))));
      ey_q[1] <= sat32(66'(ONE - 34'(ry_i)));
      c1_q    <= '{cs: cs_i, sn: sn_i, dx: dx_i, dy: dy_i, dw: dw_i, dh: dh_i};
      s1_q    <= side_i;
    end
  end

  // scale by destination size
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        mx_q[k] <= ex_q[k] * c1_q.dw;
        my_q[k] <= ey_q[k] * c1_q.dh;
      end
      c2_q <= c1_q;
      s2_q <= s1_q;
    end
  end

  // drop fraction bits and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        px_q[k] <= sat32(66'(mx_q[k] >>> FRAC_BITS));
        py_q[k] <= sat32(66'(my_q[k] >>> FRAC_BITS));
      end
      c3_q <= c2_q;
      s3_q <= s2_q;
    end
  end

  // rotation products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        pxc_q[k] <= px_q[k] * c3_q.cs;
        pxs_q[k] <= px_q[k] * c3_q.sn;
        pyc_q[k] <= py_q[k] * c3_q.cs;
        pys_q[k] <= py_q[k] * c3_q.sn;
      end
      c4_q <= c3_q;
      s4_q <= s3_q;
    end
  end

  // translate each corner, corners in order (0,0),(1,0),(1,1),(0,1)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        vx_q[j] <= sat32(66'(c4_q.dx) + 66'(pxc_q[(j == 1 || j == 2) ? 1 : 0] >>> 30)
                         - 66'(pys_q[(j >= 2) ? 1 : 0] >>> 30));
        vy_q[j] <= sat32(66'(c4_q.dy) + 66'(pxs_q[(j == 1 || j == 2) ? 1 : 0] >>> 30)
                         + 66'(pyc_q[(j >= 2) ? 1 : 0] >>> 30));
      end
      s5_q <= s4_q;
    end
  end

  assign vx_o   = vx_q;
  assign vy_o   = vy_q;
  assign side_o = s5_q;

endmodule
`default_nettype wire

>>> design/sprite_quad_vertex_setup_unit.sv
// top level: configuration registers, divider and cordic lanes, vertex math and output serializer
`timescale 1ns / 1ps
`default_nettype none
// Turns one sprite description per transaction into four vertex transactions in corner
// order (0,0),(1,0),(1,1),(0,1), with last_vertex set on the fourth. The datapath is one
// lock-step pipeline that can take a sprite in every cycle unless the output holds it:
// the four-vertex output serializer stalls the whole pipeline until the fourth vertex
// of the sprite at its end has been taken. From input transaction to the first vertex
// the path runs through the bit-per-stage dividers for origin ratio and texture
// coordinates, then five stages of vertex math. tex_width (index 0) and tex_height
// (index 1) reset to 1 and are written through the always-ready configuration channel.
module sprite_quad_vertex_setup_unit #(
  parameter int unsigned FRAC_BITS    = sqvs_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = sqvs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sqvs_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sqvs_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [14:0]         cfg_data_i
);

  localparam int unsigned DIV_NW    = 32 + FRAC_BITS;
  localparam int unsigned DIV_DEPTH = DIV_NW + 2;
  localparam int unsigned CDEPTH    = CORDIC_STEPS + 4;
  localparam int unsigned PAD       = DIV_DEPTH - CDEPTH;
  localparam int unsigned TOTAL     = DIV_DEPTH + 5;

  typedef struct packed {
    logic [63:0]        dest_pos;
    logic [63:0]        dest_size;
    logic signed [31:0] depth;
    logic [31:0]        color;
    logic [1:0]         flip;
    logic [1:0]         orient;
    logic [7:0]         swizzle;
  } carry_t;

  // configuration registers
  logic [14:0] tex_w_q, tex_w_d;
  logic [14:0] tex_h_q, tex_h_d;

  always_comb begin
    tex_w_d = tex_w_q;
    tex_h_d = tex_h_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sqvs_pkg::CFG_TEX_WIDTH:  tex_w_d = cfg_data_i;
        sqvs_pkg::CFG_TEX_HEIGHT: tex_h_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= 15'd1;
      tex_h_q <= 15'd1;
    end else begin
      tex_w_q <= tex_w_d;
      tex_h_q <= tex_h_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline advance and valid chain
  logic       en;
  logic       out_fire;
  logic [1:0] j_q, j_d;
  logic       v_q [TOTAL];

  assign out_fire   = out_valid_o && !out_stall_i;
  assign en         = !v_q[TOTAL-1] || (out_fire && (j_q == 2'd3));
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOTAL; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < TOTAL; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // divider operands
  logic signed [31:0] ox, oy, sw, sh, sxp, syp;
  logic [30:0]        den_w, den_h, den_tu, den_tv;
  logic signed [DIV_NW:0] num_ox, num_oy, num_tu0, num_tu1, num_tv0, num_tv1;

  always_comb begin
    ox  = $signed(in_data_i.origin_pt[31:0]);
    oy  = $signed(in_data_i.origin_pt[63:32]);
    sw  = $signed(in_data_i.src_size[31:0]);
    sh  = $signed(in_data_i.src_size[63:32]);
    sxp = $signed(in_data_i.src_pos[31:0]);
    syp = $signed(in_data_i.src_pos[63:32]);
    num_ox  = (DIV_NW + 1)'(ox) <<< FRAC_BITS;
    num_oy  = (DIV_NW + 1)'(oy) <<< FRAC_BITS;
    num_tu0 = (DIV_NW + 1)'(sxp);
    num_tu1 = (DIV_NW + 1)'(sxp) + (DIV_NW + 1)'(sw);
    num_tv0 = (DIV_NW + 1)'(syp);
    num_tv1 = (DIV_NW + 1)'(syp) + (DIV_NW + 1)'(sh);
    den_w   = (sw < 32'sd1) ? 31'd1 : sw[30:0];
    den_h   = (sh < 32'sd1) ? 31'd1 : sh[30:0];
    den_tu  = (tex_w_q == 15'd0) ? 31'd1 : 31'(tex_w_q);
    den_tv  = (tex_h_q == 15'd0) ? 31'd1 : 31'(tex_h_q);
  end

  logic signed [31:0] rx, ry, tu0, tu1, tv0, tv1;

  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_ox (
    .clk_i(clk_i), .en_i(en), .num_i(num_ox), .den_i(den_w), .quo_o(rx));
  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_oy (
    .clk_i(clk_i), .en_i(en), .num_i(num_oy), .den_i(den_h), .quo_o(ry));
  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_tu0 (
    .clk_i(clk_i), .en_i(en), .num_i(num_tu0), .den_i(den_tu), .quo_o(tu0));
  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_tu1 (
    .clk_i(clk_i), .en_i(en), .num_i(num_tu1), .den_i(den_tu), .quo_o(tu1));
  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_tv0 (
    .clk_i(clk_i), .en_i(en), .num_i(num_tv0), .den_i(den_tv), .quo_o(tv0));
  sqvs_div #(.NUM_W(DIV_NW), .DEN_W(31)) u_div_tv1 (
    .clk_i(clk_i), .en_i(en), .num_i(num_tv1), .den_i(den_tv), .quo_o(tv1));

  // cos and sin, padded to the divider latency
  logic signed [31:0] cs_raw, sn_raw;
  logic signed [31:0] cs_pad_q [PAD];
  logic signed [31:0] sn_pad_q [PAD];

  sqvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .en_i(en), .rot_i(in_data_i.rotation), .cos_o(cs_raw), .sin_o(sn_raw));

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_pad_q[0] <= cs_raw;
      sn_pad_q[0] <= sn_raw;
      for (int k = 1; k < PAD; k++) begin
        cs_pad_q[k] <= cs_pad_q[k-1];
        sn_pad_q[k] <= sn_pad_q[k-1];
      end
    end
  end

  // sprite fields that ride along the divider lanes
  carry_t carry_q [DIV_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      carry_q[0] <= '{dest_pos: in_data_i.dest_pos, dest_size: in_data_i.dest_size,
                      depth: in_data_i.depth, color: in_data_i.color,
                      flip: in_data_i.flip_effects, orient: in_data_i.orientation,
                      swizzle: in_data_i.swizzle};
      for (int k = 1; k < DIV_DEPTH; k++) begin
        carry_q[k] <= carry_q[k-1];
      end
    end
  end

  // vertex math
  carry_t             cr;
  sqvs_pkg::side_t    side_in, side_out;
  logic [3:0][31:0]   vx, vy;

  assign cr      = carry_q[DIV_DEPTH-1];
  assign side_in = '{tu0: tu0, tu1: tu1, tv0: tv0, tv1: tv1, depth: cr.depth,
                     color: cr.color, flip: cr.flip, orient: cr.orient, swizzle: cr.swizzle};

  sqvs_vtx #(.FRAC_BITS(FRAC_BITS)) u_vtx (
    .clk_i (clk_i),
    .en_i  (en),
    .rx_i  (rx),
    .ry_i  (ry),
    .cs_i  (cs_pad_q[PAD-1]),
    .sn_i  (sn_pad_q[PAD-1]),
    .dx_i  ($signed(cr.dest_pos[31:0])),
    .dy_i  ($signed(cr.dest_pos[63:32])),
    .dw_i  ($signed(cr.dest_size[31:0])),
    .dh_i  ($signed(cr.dest_size[63:32])),
    .side_i(side_in),
    .vx_o  (vx),
    .vy_o  (vy),
    .side_o(side_out)
  );

  // vertex counter
  always_comb begin
    j_d = j_q;
    if (out_fire) begin
      j_d = j_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= 2'd0;
    end else begin
      j_q <= j_d;
    end
  end

  // vertex select and texture corner
  logic [1:0] tc;
  assign tc = (j_q ^ side_out.flip) + side_out.orient;

  always_comb begin
    out_data_o.pos_x       = $signed(vx[j_q]);
    out_data_o.pos_y       = $signed(vy[j_q]);
    out_data_o.pos_z       = side_out.depth;
    out_data_o.color_out   = side_out.color;
    out_data_o.tex_u       = (tc == 2'd1 || tc == 2'd2) ? side_out.tu1 : side_out.tu0;
    out_data_o.tex_v       = tc[1] ? side_out.tv1 : side_out.tv0;
    out_data_o.swizzle_out = side_out.swizzle;
    out_data_o.last_vertex = (j_q == 2'd3);
  end

  assign out_valid_o = v_q[TOTAL-1];

endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench for the sprite quad vertex setup unit: directed and random sprites, scoreboard check
`timescale 1ns / 1ps
`default_nettype none
module tb;

  // fixed-point helpers for the vertex predictor
  function automatic longint sat_q32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lo_s32(logic [63:0] w);
    logic signed [31:0] t;
    t = w[31:0];
    return longint'(t);
  endfunction

  function automatic longint hi_s32(logic [63:0] w);
    logic signed [31:0] t;
    t = w[63:32];
    return longint'(t);
  endfunction

  // rotation-mode cordic, cos and sin with 30 fraction bits
  function automatic void rot_cos_sin(longint ang, output longint c, output longint s);
    longint x, y, nx, a;
    bit flip;
    a = ang;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (a > 64'sd3373259426) a -= 64'sd6746518852;
    else if (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < sqvs_pkg::CORDIC_STEPS_DEF; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= longint'(sqvs_pkg::ATAN_Q30[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += longint'(sqvs_pkg::ATAN_Q30[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // expected vertices and checking
  class quad_scoreboard;
    sqvs_pkg::out_item_t pending_verts[$];
    int unsigned mismatches;
    logic [14:0] tex_w, tex_h;

    function new();
      mismatches = 0;
      tex_w = 1;
      tex_h = 1;
    endfunction

    function void note_sprite(sqvs_pkg::in_item_t sp);
      longint one, dx, dy, dw, dh, sw, sh, rx, ry, cs, sn, cx, cy, px, py, tu, tv, tw, th;
      sqvs_pkg::out_item_t v;
      int unsigned t;
      one = 64'sd1 << sqvs_pkg::FRAC_BITS_DEF;
      dx = lo_s32(sp.dest_pos);  dy = hi_s32(sp.dest_pos);
      dw = lo_s32(sp.dest_size); dh = hi_s32(sp.dest_size);
      sw = lo_s32(sp.src_size);  sh = hi_s32(sp.src_size);
      tw = (tex_w == 0) ? 1 : longint'(tex_w);
      th = (tex_h == 0) ? 1 : longint'(tex_h);
      cs = 64'sd1 << 30;
      sn = 0;
      if (sp.rotation != 0) rot_cos_sin(longint'(sp.rotation) * 262144, cs, sn);
      rx = sat_q32((lo_s32(sp.origin_pt) * one) / (sw < 1 ? 1 : sw));
      ry = sat_q32((hi_s32(sp.origin_pt) * one) / (sh < 1 ? 1 : sh));
      for (int j = 0; j < 4; j++) begin
        cx = (j == 1 || j == 2) ? one : 0;
        cy = (j >= 2) ? one : 0;
        px = sat_q32((sat_q32(cx - rx) * dw) >>> sqvs_pkg::FRAC_BITS_DEF);
        py = sat_q32((sat_q32(cy - ry) * dh) >>> sqvs_pkg::FRAC_BITS_DEF);
        v.pos_x = sat_q32(dx + ((px * cs) >>> 30) - ((py * sn) >>> 30));
        v.pos_y = sat_q32(dy + ((px * sn) >>> 30) + ((py * cs) >>> 30));
        v.pos_z = sp.depth;
        v.color_out = sp.color;
        t = ((j ^ sp.flip_effects) + sp.orientation) & 3;
        tu = lo_s32(sp.src_pos) + ((t == 1 || t == 2) ? sw : 0);
        tv = hi_s32(sp.src_pos) + ((t >= 2) ? sh : 0);
        v.tex_u = sat_q32(tu / tw);
        v.tex_v = sat_q32(tv / th);
        v.swizzle_out = sp.swizzle;
        v.last_vertex = (j == 3);
        pending_verts.push_back(v);
      end
    endfunction

    function void check_vertex(sqvs_pkg::out_item_t got);
      sqvs_pkg::out_item_t exp_v;
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
        return;
      end
      exp_v = pending_verts.pop_front();
      if (got !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch: x %h/%h y %h/%h z %h/%h c %h/%h u %h/%h v %h/%h s %h/%h l %b/%b",
                   exp_v.pos_x, got.pos_x, exp_v.pos_y, got.pos_y, exp_v.pos_z, got.pos_z,
                   exp_v.color_out, got.color_out, exp_v.tex_u, got.tex_u,
                   exp_v.tex_v, got.tex_v, exp_v.swizzle_out, got.swizzle_out,
                   exp_v.last_vertex, got.last_vertex);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  sqvs_pkg::in_item_t in_data;
  sqvs_pkg::out_item_t out_data;
  logic [7:0] cfg_index;
  logic [14:0] cfg_data;

  quad_scoreboard sb;
  int unsigned hold_cycles;
  bit stall_random;

  sprite_quad_vertex_setup_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  // result side: random stall, plus long hold-off when requested
  initial begin
    int unsigned gap;
    out_stall = 1;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_vertex(out_data);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
        if (stall_random && out_valid && !out_stall) gap = $urandom_range(0, 8);
      end
    end
  end

  // configuration register write transaction, caller drops valid after the last one
  task automatic write_reg(logic [7:0] idx, logic [14:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sqvs_pkg::CFG_TEX_WIDTH) sb.tex_w = val;
    else sb.tex_h = val;
  endtask

  // sprite transaction, with optional random gap ahead
  task automatic send_sprite(sqvs_pkg::in_item_t sp, bit gaps);
    int unsigned g;
    g = gaps ? $urandom_range(0, 8) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= sp;
    do @(posedge clk); while (in_stall);
    sb.note_sprite(sp);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_verts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // a q16.16 value of modest size, either sign
  function automatic logic [31:0] rnd_q(int unsigned span);
    return $urandom_range(0, 1) ? -$urandom_range(0, span) : $urandom_range(0, span);
  endfunction

  function automatic sqvs_pkg::in_item_t rnd_sprite();
    sqvs_pkg::in_item_t sp;
    if ($urandom_range(0, 4) == 0) begin
      sp = {rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), 16'($urandom), $urandom,
            $urandom, 2'($urandom), 2'($urandom), 8'($urandom)};
    end else begin
      sp.dest_pos = {rnd_q(32'h0400_0000), rnd_q(32'h0400_0000)};
      sp.dest_size = {rnd_q(32'h0100_0000), rnd_q(32'h0100_0000)};
      sp.src_pos = {rnd_q(32'h0400_0000), rnd_q(32'h0400_0000)};
      sp.src_size = {rnd_q(32'h0100_0000), rnd_q(32'h0100_0000)};
      sp.origin_pt = {rnd_q(32'h0100_0000), rnd_q(32'h0100_0000)};
      sp.rotation = ($urandom_range(0, 5) == 0) ? 16'sd0 : 16'($urandom);
      sp.depth = $urandom;
      sp.color = $urandom;
      sp.flip_effects = 2'($urandom);
      sp.orientation = 2'($urandom);
      sp.swizzle = 8'($urandom);
    end
    return sp;
  endfunction

  // stimulus
  initial begin
    sqvs_pkg::in_item_t sp;
    logic [14:0] tex_vals[6];
    sb = new();
    hold_cycles = 0;
    stall_random = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = sqvs_pkg::CFG_TEX_WIDTH;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed sprites at the reset texture size
    for (int k = 0; k < 16; k++) begin
      sp = rnd_sprite();
      sp.flip_effects = k[1:0];
      sp.orientation = k[3:2];
      case (k)
        0: sp.rotation = 16'sd0;
        1: sp.rotation = 16'sh7FFF;
        2: sp.rotation = 16'sh8000;
        3: sp.rotation = 16'sd6434;
        4: sp.rotation = -16'sd6434;
        5: sp.src_size = 64'h0;
        6: sp.src_size = {32'hFFFF_0000, 32'h8000_0000};
        7: begin
          sp.dest_pos = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          sp.dest_size = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          sp.origin_pt = {32'h8000_0000, 32'h8000_0000};
          sp.src_size = 64'h0000_0001_0000_0001;
        end
        8: begin
          sp.dest_pos = {32'h8000_0000, 32'h8000_0000};
          sp.dest_size = {32'h8000_0000, 32'h8000_0000};
          sp.origin_pt = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        9: begin
          sp.src_pos = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
          sp.src_size = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        10: begin
          sp.src_pos = 64'hFFFF_FFFF_FFFF_FFFF;
          sp.depth = 32'h8000_0000;
          sp.color = 32'hFFFF_FFFF;
          sp.swizzle = 8'hFF;
        end
        11: begin
          sp = '0;
          sp.flip_effects = 2'd3;
          sp.orientation = 2'd2;
        end
        default: ;
      endcase
      send_sprite(sp, 0);
    end
    drain();

    // texture size settings, extremes and zero among them
    tex_vals = '{15'd16384, 15'd0, 15'd3, 15'h7FFF, 15'd1, 15'd640};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sqvs_pkg::CFG_TEX_WIDTH, tex_vals[ph]);
      write_reg(sqvs_pkg::CFG_TEX_HEIGHT, tex_vals[(ph + 3) % 6]);
      cfg_valid <= 0;
      stall_random = (ph % 2 == 0);
      for (int k = 0; k < 42; k++) send_sprite(rnd_sprite(), ph != 3);
      if (ph == 1) begin
        // long receiver hold-off while sprites keep coming
        hold_cycles = 300;
        for (int k = 0; k < 30; k++) send_sprite(rnd_sprite(), 0);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_verts.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
